@@ rtl/s6enc_pkg.sv @@
// ----------------------------------------------------------------------------
// s6enc_pkg
// Shared types and constants for the six-bit text encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s6enc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int CHAR_COUNT_W = 16;

  localparam logic [6:0] CHAR_OFFSET = 7'h3C;
  localparam logic [5:0] CODE_MASK = 6'h3F;
  localparam logic [15:0] OUTPUT_LIMIT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [6:0]              code_char;
    logic                    char_valid;
    logic                    end_of_message;
    logic [CHAR_COUNT_W-1:0] char_count;
  } out_t;

  typedef struct packed {
    logic [1:0] num;
    out_t       first;
    out_t       second;
  } res_t;

endpackage

@@ rtl/six_bit_text_encoder.sv @@
// ----------------------------------------------------------------------------
// six_bit_text_encoder
// Packs a byte stream into printable six-bit characters (code plus 0x3C).
// ----------------------------------------------------------------------------
// Each request carries one message byte and a last flag; it is registered,
// encoded and written as one or two result requests into a two-slot output
// buffer. The output channel delivers one character per cycle while out_stall
// is low. The buffer takes a byte's results only when empty or as its last
// result is taken, so a byte that yields two (every third byte of a group, or
// a last byte that flushes leftover bits) holds up the next byte. The
// character limit, written through cfg_we and cfg_data, resets to 65535; the
// user must write it only while the encoder is idle; the block does not enforce it.
`timescale 1ns / 1ps

module six_bit_text_encoder
  import s6enc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data
);

  logic item_valid;
  in_t  item;
  logic space;
  logic advance;
  res_t res;

  assign advance  = item_valid && space;
  assign in_stall = item_valid && !space;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  s6enc_core #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .advance  (advance),
    .item     (item),
    .res      (res)
  );

  s6enc_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (advance),
    .res       (res),
    .space     (space),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ rtl/s6enc_core.sv @@
// ----------------------------------------------------------------------------
// s6enc_core
// Encoder state, limit register and the single-pass encode of one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s6enc_core
  import s6enc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        advance,
  input  in_t         item,
  output res_t        res
);

  localparam int LW = (COUNT_WIDTH > CHAR_COUNT_W) ? COUNT_WIDTH : CHAR_COUNT_W;

  logic [15:0]            output_limit;
  logic [1:0]             bit_phase, bit_phase_next;
  logic [5:0]             carry_bits, carry_bits_next;
  logic [COUNT_WIDTH-1:0] emitted_count, emitted_count_next;

  logic [LW:0]            count_max, limit_x, lim, cnt_x, cnt1_x;
  logic [COUNT_WIDTH-1:0] cnt1, cnt2;
  logic [5:0]             made, rest;
  logic                   active, room, phase_two, second;
  logic                   last;

  function automatic logic [CHAR_COUNT_W-1:0] to_count(input logic [COUNT_WIDTH-1:0] v);
    logic [LW-1:0] t;
    t = LW'(v);
    return t[CHAR_COUNT_W-1:0];
  endfunction

  function automatic logic [6:0] to_char(input logic [5:0] code);
    return 7'({1'b0, code & CODE_MASK}) + CHAR_OFFSET;
  endfunction

  always_comb begin
    last      = item.last_byte;
    count_max = {{(LW + 1 - COUNT_WIDTH){1'b0}}, {COUNT_WIDTH{1'b1}}};
    limit_x   = (LW + 1)'(output_limit);
    lim       = (limit_x < count_max) ? limit_x : count_max;
    cnt_x     = (LW + 1)'(emitted_count);
    cnt1_x    = cnt_x + (LW + 1)'(1);
    cnt1      = emitted_count + COUNT_WIDTH'(1);
    cnt2      = emitted_count + COUNT_WIDTH'(2);
    active    = cnt_x < lim;
    room      = cnt1_x < lim;
    phase_two = (bit_phase != 2'd0) && (bit_phase != 2'd1);

    case (bit_phase)
      2'd0: begin
        made = carry_bits | item.data_byte[7:2];
        rest = {item.data_byte[1:0], 4'b0000};
      end
      2'd1: begin
        made = carry_bits | {2'b00, item.data_byte[7:4]};
        rest = {item.data_byte[3:0], 2'b00};
      end
      default: begin
        made = carry_bits | {4'b0000, item.data_byte[7:6]};
        rest = item.data_byte[5:0];
      end
    endcase

    second = active && room && (phase_two || last);

    res = '0;
    if (active) begin
      res.num                  = second ? 2'd2 : 2'd1;
      res.first.code_char      = to_char(made);
      res.first.char_valid     = 1'b1;
      res.first.end_of_message = last && !second;
      res.first.char_count     = to_count(cnt1);
      res.second.code_char     = to_char(rest);
      res.second.char_valid    = 1'b1;
      res.second.end_of_message = last;
      res.second.char_count    = to_count(cnt2);
    end else if (last) begin
      res.num                  = 2'd1;
      res.first.end_of_message = 1'b1;
      res.first.char_count     = to_count(emitted_count);
    end

    bit_phase_next     = bit_phase;
    carry_bits_next    = carry_bits;
    emitted_count_next = emitted_count;
    if (last) begin
      bit_phase_next     = 2'd0;
      carry_bits_next    = '0;
      emitted_count_next = '0;
    end else if (active) begin
      if (phase_two) begin
        bit_phase_next     = 2'd0;
        carry_bits_next    = '0;
        emitted_count_next = second ? cnt2 : cnt1;
      end else begin
        bit_phase_next     = bit_phase + 2'd1;
        carry_bits_next    = rest;
        emitted_count_next = cnt1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit  <= OUTPUT_LIMIT_RESET;
      bit_phase     <= 2'd0;
      carry_bits    <= '0;
      emitted_count <= '0;
    end else begin
      if (cfg_we) begin
        output_limit <= cfg_data;
      end
      if (advance) begin
        bit_phase     <= bit_phase_next;
        carry_bits    <= carry_bits_next;
        emitted_count <= emitted_count_next;
      end
    end
  end

endmodule

@@ rtl/s6enc_obuf.sv @@
// ----------------------------------------------------------------------------
// s6enc_obuf
// Two-slot result buffer; up to two in at once, one out each unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s6enc_obuf
  import s6enc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t res,
  output logic space,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  logic [1:0] fill, fill_next;
  out_t       slot0, slot1;
  logic       pop;

  always_comb begin
    pop       = out_valid && !out_stall;
    space     = (fill == 2'd0) || ((fill == 2'd1) && pop);
    fill_next = fill;
    if (push) begin
      fill_next = res.num;
    end else if (pop) begin
      fill_next = fill - 2'd1;
    end
  end

  assign out_valid = fill != 2'd0;
  assign out_data  = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot0 <= res.first;
      slot1 <= res.second;
    end else if (pop) begin
      slot0 <= slot1;
    end
  end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the six-bit text encoder. A driver and a monitor
// run as clocked processes. Each accepted byte request goes through a local
// encoder model that queues the characters it should produce. Each delivered
// character is checked field by field against the oldest queued one. Directed
// messages cover the limit corner cases. Random messages follow, under several
// limits, with bursty input, patterned output stall and one long output hold.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import s6enc_pkg::*;

  typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  in_t         byte_queue[$];
  out_t        pending_chars[$];
  out_t        want_char;
  int          err_count = 0;

  logic [1:0]  enc_phase = '0;
  logic [5:0]  enc_carry = '0;
  int unsigned enc_count = 0;
  int unsigned char_limit = OUTPUT_LIMIT_RESET;

  int          burst_left = 0;
  int          gap_left = 0;
  rx_mode_t    stall_mode = RX_FLOW;
  int          mode_left = 0;
  int          hold_left = 0;
  bit          hold_done = 1'b0;
  int          rx_seen = 0;

  six_bit_text_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic out_t make_char(input int unsigned code);
    out_t c;
    c = '0;
    c.code_char = code[6:0] + CHAR_OFFSET;
    c.char_valid = 1'b1;
    c.char_count = enc_count[15:0];
    return c;
  endfunction

  task automatic encode_byte(input in_t req);
    int unsigned p;
    int unsigned b;
    int unsigned made;
    int unsigned rest;
    bit two;
    out_t res[2];
    int n;
    b = req.data_byte;
    n = 0;
    if (enc_count < char_limit) begin
      p = (enc_phase > 2) ? 2 : enc_phase;
      made = (enc_carry | (b >> (2 + 2 * p))) & CODE_MASK;
      rest = (b << (4 - 2 * p)) & CODE_MASK;
      if (p < 2) begin
        enc_count = enc_count + 1;
        res[n] = make_char(made);
        n = n + 1;
        enc_phase = 2'(p + 1);
        enc_carry = 6'(rest);
      end else begin
        two = (enc_count + 1) < char_limit;
        enc_count = enc_count + 1;
        res[n] = make_char(made);
        n = n + 1;
        if (two) begin
          enc_count = enc_count + 1;
          res[n] = make_char(rest);
          n = n + 1;
        end
        enc_phase = '0;
        enc_carry = '0;
      end
    end
    if (req.last_byte) begin
      if (enc_phase != 0 && enc_count < char_limit) begin
        enc_count = enc_count + 1;
        res[n] = make_char(enc_carry);
        n = n + 1;
      end
      if (n > 0) begin
        res[n-1].end_of_message = 1'b1;
      end else begin
        res[0] = '0;
        res[0].end_of_message = 1'b1;
        res[0].char_count = enc_count[15:0];
        n = 1;
      end
      enc_phase = '0;
      enc_carry = '0;
      enc_count = 0;
    end
    for (int i = 0; i < n; i++) pending_chars.push_back(res[i]);
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want_v);
    $display("%0t: %s: got 0x%0h, want 0x%0h", $realtime, what, got, want_v);
    err_count++;
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_byte(in_data);
        void'(byte_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // hold the stalled request
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= byte_queue[0];
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern plus one long hold
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_mode <= RX_FLOW;
      mode_left <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      rx_seen <= 0;
    end else begin
      if (out_valid && !out_stall) rx_seen <= rx_seen + 1;
      if (mode_left == 0) begin
        stall_mode <= rx_mode_t'($urandom_range(0, 3));
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (!hold_done && rx_seen >= 150) begin
        hold_done <= 1'b1;
        hold_left <= 200;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
          default:  out_stall <= ~out_stall;
        endcase
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch("unexpected result, code_char", out_data.code_char, 0);
      end else begin
        want_char = pending_chars.pop_front();
        if (out_data.code_char !== want_char.code_char)
          report_mismatch("code_char", out_data.code_char, want_char.code_char);
        if (out_data.char_valid !== want_char.char_valid)
          report_mismatch("char_valid", out_data.char_valid, want_char.char_valid);
        if (out_data.end_of_message !== want_char.end_of_message)
          report_mismatch("end_of_message", out_data.end_of_message,
                          want_char.end_of_message);
        if (out_data.char_count !== want_char.char_count)
          report_mismatch("char_count", out_data.char_count, want_char.char_count);
      end
    end
  end

  task automatic add_req(input logic [7:0] b, input logic last);
    in_t r;
    r.data_byte = b;
    r.last_byte = last;
    byte_queue.push_back(r);
  endtask

  task automatic queue_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 7))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      add_req(b, i == len - 1);
    end
  endtask

  task automatic write_limit(input int unsigned v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    char_limit = v & 16'hFFFF;
    @(negedge clk);
  endtask

  task automatic wait_idle;
    do @(negedge clk);
    while (byte_queue.size() != 0 || in_valid || pending_chars.size() != 0);
    repeat (20) @(negedge clk);
  endtask

  initial begin
    int unsigned limits[6];
    int targets[6];
    int len;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // flush after one and two bytes, full group, group plus one
    add_req(8'hFF, 1'b1);
    add_req(8'h00, 1'b0); add_req(8'hAA, 1'b1);
    add_req(8'hFF, 1'b0); add_req(8'h55, 1'b0); add_req(8'h01, 1'b1);
    add_req(8'h12, 1'b0); add_req(8'h34, 1'b0); add_req(8'h56, 1'b0);
    add_req(8'h80, 1'b1);
    wait_idle();

    // zero limit: everything dropped, bare end marker
    write_limit(0);
    add_req(8'h7F, 1'b0); add_req(8'hC3, 1'b1);
    wait_idle();

    // one slot left at group end, then dropped bytes
    write_limit(3);
    add_req(8'hAB, 1'b0); add_req(8'hCD, 1'b0); add_req(8'hEF, 1'b0);
    add_req(8'h11, 1'b0); add_req(8'h22, 1'b1);
    wait_idle();

    // flush suppressed at the limit
    write_limit(1);
    add_req(8'hF0, 1'b0); add_req(8'h0F, 1'b1);
    wait_idle();
    write_limit(2);
    add_req(8'h9C, 1'b0); add_req(8'h3E, 1'b1);
    wait_idle();

    limits = '{65535, $urandom_range(1, 8), $urandom_range(9, 40), 0,
               $urandom_range(100, 400), 65535};
    targets = '{300, 250, 250, 30, 300, 300};
    for (int ph = 0; ph < 6; ph++) begin
      write_limit(limits[ph]);
      while (byte_queue.size() < targets[ph]) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                           : $urandom_range(1, 12);
        queue_message(len);
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

endmodule
